### hdl/fvnh_pkg.sv
// Shared constants and types for the fractal value-noise height generator.
package fvnh_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int OCTAVES    = 3;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int SMOOTH_W   = FRAC_BITS + 1;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int HEIGHT_W   = 19;
    localparam int SUM_W      = VAL_W + OCTAVES;

    localparam logic [VAL_W-1:0]    ONE_FX     = VAL_W'(1) << FRAC_BITS;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [VAL_W-1:0]     val_t;
    typedef logic [SMOOTH_W-1:0]  smooth_t;

endpackage

### hdl/fvnh_ram.sv
// Generic one-write, two-read table memory with registered read data.
module fvnh_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports advance with the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### hdl/fvnh_smooth.sv
// Two-stage smoothstep unit: t*t in Q0.F, then t2 * (3 - 2t) in Q1.F.
module fvnh_smooth (
    input  logic             clk,
    input  logic             en,
    input  fvnh_pkg::frac_t  t,
    output fvnh_pkg::smooth_t s
);

    localparam int F = fvnh_pkg::FRAC_BITS;

    fvnh_pkg::frac_t   t_reg;
    fvnh_pkg::frac_t   t2_reg;
    fvnh_pkg::smooth_t s_reg;

    logic [2*F-1:0] sq;
    logic [F+1:0]   u;
    logic [2*F+1:0] prod;

    // Square of the fraction, truncated back to Q0.F.
    assign sq = {{F{1'b0}}, t} * {{F{1'b0}}, t};

    // Weight 3 - 2t and the final product.
    assign u    = ((F+2)'(3) << F) - {1'b0, t_reg, 1'b0};
    assign prod = {{(F+2){1'b0}}, t2_reg} * {{F{1'b0}}, u};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t;
            t2_reg <= sq[2*F-1:F];
            s_reg  <= prod[F +: fvnh_pkg::SMOOTH_W];
        end
    end

    assign s = s_reg;

endmodule

### hdl/fractal_value_noise_height.sv
// Top level of the fractal value-noise height generator pipeline.
//
// Usage: items arrive on the item channel (item_valid / item_ready). A load
// item (opcode 0) writes one permutation entry and its lattice value; the
// host loads every entry before it evaluates. An evaluate item (opcode 1)
// carries signed Q15.16 coordinates and yields one height (unsigned Q3.16)
// on the result channel (result_valid / result_ready). Loads give no result.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline has six register stages; the first is written at the transfer
// edge and result_valid is driven by the sixth, the output register.
// Each table read level (perm of x, perm of the hash, lattice value) sits
// in its own stage and uses its own bank of replicated memories; a load
// moves down the pipeline and writes each bank in the stage that reads it,
// so loads and evaluations keep their order.
// Reset clears all valid bits; the tables are not cleared and hold garbage
// until loaded. When the receiver stalls, the whole pipeline holds and
// item_ready drops; nothing is lost or repeated.
module fractal_value_noise_height (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             opcode,
    input  logic [fvnh_pkg::IDX_W-1:0]       entry_index,
    input  logic [fvnh_pkg::IDX_W-1:0]       perm_value,
    input  logic [fvnh_pkg::VAL_W-1:0]       random_value,
    input  logic signed [fvnh_pkg::COORD_W-1:0] coord_x,
    input  logic signed [fvnh_pkg::COORD_W-1:0] coord_y,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [fvnh_pkg::HEIGHT_W-1:0]    height
);

    localparam int OCT = fvnh_pkg::OCTAVES;
    localparam int FB  = fvnh_pkg::FRAC_BITS;
    localparam int IW  = fvnh_pkg::IDX_W;

    // Linear blend, exact form of (a*(1-s) + b*s) >> F.
    function automatic fvnh_pkg::val_t lerp(fvnh_pkg::val_t a, fvnh_pkg::val_t b,
                                             fvnh_pkg::smooth_t s);
        logic signed [fvnh_pkg::DIFF_W-1:0]                   d;
        logic signed [fvnh_pkg::DIFF_W+fvnh_pkg::SMOOTH_W:0]  p;
        logic signed [fvnh_pkg::DIFF_W+fvnh_pkg::SMOOTH_W:0]  r;
        d = signed'({1'b0, b}) - signed'({1'b0, a});
        p = d * signed'({1'b0, s});
        r = signed'({{(fvnh_pkg::SMOOTH_W+2){1'b0}}, a}) + (p >>> FB);
        return r[fvnh_pkg::VAL_W-1:0];
    endfunction

    logic en;
    logic in_fire;

    // Stage 1 registers.
    logic                  v1_reg;
    fvnh_pkg::op_t         op1_reg;
    fvnh_pkg::idx_t        idx1_reg;
    fvnh_pkg::idx_t        pv1_reg;
    fvnh_pkg::val_t        rv1_reg;
    fvnh_pkg::idx_t        y0_1_reg [OCT];
    fvnh_pkg::idx_t        y1_1_reg [OCT];
    fvnh_pkg::frac_t       fx1_reg  [OCT];
    fvnh_pkg::frac_t       fy1_reg  [OCT];

    // Stage 2 registers.
    logic                  v2_reg;
    fvnh_pkg::op_t         op2_reg;
    fvnh_pkg::idx_t        idx2_reg;
    fvnh_pkg::val_t        rv2_reg;

    // Later stages.
    logic                  v3_reg;
    logic                  v4_reg;
    logic                  v5_reg;
    fvnh_pkg::smooth_t     sy4_reg [OCT];
    fvnh_pkg::val_t        lo4_reg [OCT];
    fvnh_pkg::val_t        hi4_reg [OCT];
    fvnh_pkg::val_t        n5_reg  [OCT];
    logic                  out_valid_reg;
    logic [fvnh_pkg::HEIGHT_W-1:0] height_reg;
    logic [fvnh_pkg::HEIGHT_W-1:0] height_next;

    // Combinational lattice split and memory traffic.
    fvnh_pkg::idx_t        x0_a [OCT];
    fvnh_pkg::idx_t        x1_a [OCT];
    fvnh_pkg::idx_t        y0_a [OCT];
    fvnh_pkg::frac_t       fx_a [OCT];
    fvnh_pkg::frac_t       fy_a [OCT];
    fvnh_pkg::idx_t        px   [OCT][2];
    fvnh_pkg::idx_t        ph   [OCT][2][2];
    fvnh_pkg::val_t        cv   [OCT][2][2];
    fvnh_pkg::smooth_t     sx   [OCT];
    fvnh_pkg::smooth_t     sy   [OCT];
    fvnh_pkg::val_t        rv_sat;
    logic [fvnh_pkg::SUM_W-1:0] sum;

    logic we_a;
    logic we_b;
    logic we_c;

    // The pipeline moves whenever the output register is free or drains.
    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;
    assign in_fire    = item_valid && en;

    assign we_a = in_fire && (opcode == fvnh_pkg::OP_LOAD);
    assign we_b = en && v1_reg && (op1_reg == fvnh_pkg::OP_LOAD);
    assign we_c = en && v2_reg && (op2_reg == fvnh_pkg::OP_LOAD);

    // Lattice values above one are stored as one.
    assign rv_sat = (random_value > fvnh_pkg::ONE_FX) ? fvnh_pkg::ONE_FX : random_value;

    // Per-octave floor, wrap and fraction of the shifted coordinates.
    always_comb
    begin
        logic signed [fvnh_pkg::COORD_W-1:0] shx;
        logic signed [fvnh_pkg::COORD_W-1:0] shy;
        for (int k = 0; k < OCT; k++)
        begin
            shx     = coord_x >>> k;
            shy     = coord_y >>> k;
            x0_a[k] = shx[FB +: IW];
            x1_a[k] = shx[FB +: IW] + IW'(1);
            y0_a[k] = shy[FB +: IW];
            fx_a[k] = shx[FB-1:0];
            fy_a[k] = shy[FB-1:0];
        end
    end

    // Memory banks: perm of x, perm of the hash, lattice value.
    for (genvar k = 0; k < OCT; k++)
    begin : g_oct
        fvnh_ram #(.DATA_W(IW), .ADDR_W(IW)) u_perm_x (
            .clk     (clk),
            .en      (en),
            .we      (we_a),
            .waddr   (entry_index),
            .wdata   (perm_value),
            .raddr_a (x0_a[k]),
            .raddr_b (x1_a[k]),
            .rdata_a (px[k][0]),
            .rdata_b (px[k][1])
        );

        for (genvar r = 0; r < 2; r++)
        begin : g_row
            fvnh_pkg::idx_t yr;
            assign yr = (r == 0) ? y0_1_reg[k] : y1_1_reg[k];

            fvnh_ram #(.DATA_W(IW), .ADDR_W(IW)) u_perm_h (
                .clk     (clk),
                .en      (en),
                .we      (we_b),
                .waddr   (idx1_reg),
                .wdata   (pv1_reg),
                .raddr_a (px[k][0] + yr),
                .raddr_b (px[k][1] + yr),
                .rdata_a (ph[k][r][0]),
                .rdata_b (ph[k][r][1])
            );

            fvnh_ram #(.DATA_W(fvnh_pkg::VAL_W), .ADDR_W(IW)) u_value (
                .clk     (clk),
                .en      (en),
                .we      (we_c),
                .waddr   (idx2_reg),
                .wdata   (rv2_reg),
                .raddr_a (ph[k][r][0]),
                .raddr_b (ph[k][r][1]),
                .rdata_a (cv[k][r][0]),
                .rdata_b (cv[k][r][1])
            );
        end

        fvnh_smooth u_smooth_x (
            .clk (clk),
            .en  (en),
            .t   (fx1_reg[k]),
            .s   (sx[k])
        );

        fvnh_smooth u_smooth_y (
            .clk (clk),
            .en  (en),
            .t   (fy1_reg[k]),
            .s   (sy[k])
        );
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= fvnh_pkg::op_t'(opcode);
            idx1_reg <= entry_index;
            pv1_reg  <= perm_value;
            rv1_reg  <= rv_sat;
            op2_reg  <= op1_reg;
            idx2_reg <= idx1_reg;
            rv2_reg  <= rv1_reg;
            for (int k = 0; k < OCT; k++)
            begin
                y0_1_reg[k] <= y0_a[k];
                y1_1_reg[k] <= y0_a[k] + IW'(1);
                fx1_reg[k]  <= fx_a[k];
                fy1_reg[k]  <= fy_a[k];
                sy4_reg[k]  <= sy[k];
                lo4_reg[k]  <= lerp(cv[k][0][0], cv[k][0][1], sx[k]);
                hi4_reg[k]  <= lerp(cv[k][1][0], cv[k][1][1], sx[k]);
                n5_reg[k]   <= lerp(lo4_reg[k], hi4_reg[k], sy4_reg[k]);
            end
            height_reg <= height_next;
        end
    end

    // Octave sum with saturation.
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < OCT; k++)
        begin
            sum = sum + (fvnh_pkg::SUM_W'(n5_reg[k]) << k);
        end
        if (sum > fvnh_pkg::SUM_W'(fvnh_pkg::HEIGHT_MAX))
        begin
            height_next = fvnh_pkg::HEIGHT_MAX;
        end
        else
        begin
            height_next = sum[fvnh_pkg::HEIGHT_W-1:0];
        end
    end

    // Valid bits; loads leave the pipeline after the last table write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= item_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg && (op2_reg == fvnh_pkg::OP_EVAL);
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign height       = height_reg;

    // A stall freezes every stage valid bit, v1 to v5.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}))
        else $error("pipeline moved during a stall");

    // A new result always comes from the last stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v5_reg))
        else $error("result appeared without a finished item");

    // The value tables are written only by load items.
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        we_c |-> (v2_reg && (op2_reg == fvnh_pkg::OP_LOAD)))
        else $error("value table written by a non-load item");

    // Height stays inside its field range.
    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (height_reg <= fvnh_pkg::HEIGHT_MAX))
        else $error("height out of range");

endmodule
